/* sv/gmdc_pkg.sv */
package gmdc_pkg;

  // fixed field widths
  localparam int CELL_W   = 12;
  localparam int REG_W    = 7;
  localparam int CFG_IDX_W = 1;

  // grid capacity
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_CARVED    = 3'd1;
  localparam logic [2:0] ST_BACKTRACK = 3'd2;
  localparam logic [2:0] ST_STALLED   = 3'd3;
  localparam logic [2:0] ST_FINISHED  = 3'd4;
  localparam logic [2:0] ST_READ_DATA = 3'd5;

  // one word of the cell memory
  typedef struct packed {
    logic       loaded;
    logic       blocked;
    logic       visited;
    logic [3:0] walls;
  } cell_word_t;

endpackage

/* sv/grid_maze_dfs_carver.sv */
// load, start, read: decode, then write or capture the cell, skipped outside the grid; step:
//   division, neighbor reads (both skipped off grid), carve or pop; skipped when finished
// throughput: one item at a time, next transfer taken as soon as the result is
//   registered, even while that result still waits on out_ready
// reset: synchronous, active low; then a clearing pass over all MAX_COLUMNS*MAX_ROWS
//   (4096) cells of the cell memory during which no item is taken
module grid_maze_dfs_carver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic [gmdc_pkg::CELL_W-1:0]    in_cell_req,
  input  logic                           in_blocked,
  input  logic [7:0]                     in_random_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [gmdc_pkg::CELL_W-1:0]    out_current_cell,
  output logic [1:0]                     out_carved_direction,
  output logic [3:0]                     out_wall_bits,
  output logic [12:0]                    out_cells_left,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gmdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmdc_pkg::REG_W-1:0]     cfg_data
);
  import gmdc_pkg::*;

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int LVL_W  = $clog2(CELLS + 1);
  localparam int WORD_W = $bits(cell_word_t);
  localparam int TOT_W  = 2 * REG_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_LD_WR, S_ST_WR, S_RD_CAP, S_DIV_WAIT,
    S_NB, S_CHOOSE, S_CV_CUR, S_CV_NXT, S_POP, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic               blk_r, blk_nxt;
  logic [7:0]         rnd_r, rnd_nxt;
  logic [REG_W-1:0]   grid_w_r, grid_w_nxt;
  logic [REG_W-1:0]   grid_h_r, grid_h_nxt;
  logic [TOT_W-1:0]   total_r;
  logic [CELL_W-1:0]  walker_r, walker_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [LVL_W-1:0]   count_r, count_nxt;
  logic [2:0]         dir_cnt_r, dir_cnt_nxt;
  logic [3:0]         fresh_r, fresh_nxt;
  logic [1:0]         pick_r, pick_nxt;
  logic [CELL_W-1:0]  nxt_cell_r, nxt_cell_nxt;
  logic [2:0]         res_status_r, res_status_nxt;
  logic [1:0]         res_dir_r, res_dir_nxt;
  logic [3:0]         res_walls_r, res_walls_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [CELL_W-1:0]  out_cell_r, out_cell_nxt;
  logic [1:0]         out_dir_r, out_dir_nxt;
  logic [3:0]         out_walls_r, out_walls_nxt;
  logic [LVL_W-1:0]   out_left_r, out_left_nxt;

  // saturated grid size
  logic [8:0]         w_sat, h_sat;
  logic [REG_W-1:0]   use_w, use_h;

  always_comb begin
    if (grid_w_r == '0) begin
      w_sat = 9'd1;
    end else if (9'(grid_w_r) > 9'(MAX_COLUMNS)) begin
      w_sat = 9'(MAX_COLUMNS);
    end else begin
      w_sat = 9'(grid_w_r);
    end
    if (grid_h_r == '0) begin
      h_sat = 9'd1;
    end else if (9'(grid_h_r) > 9'(MAX_ROWS)) begin
      h_sat = 9'(MAX_ROWS);
    end else begin
      h_sat = 9'(grid_h_r);
    end
    use_w = REG_W'(w_sat);
    use_h = REG_W'(h_sat);
  end

  // cell memory and path stack
  logic               cm_we;
  logic [AW-1:0]      cm_waddr, cm_raddr;
  cell_word_t         cm_wdata, cm_rdata;
  logic               sk_we;
  logic [AW-1:0]      sk_addr_w, sk_raddr;
  logic [CELL_W-1:0]  sk_rdata;

  gmdc_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  gmdc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_addr_w),
    .wdata (walker_r),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  assign sk_addr_w = AW'(level_r);
  assign sk_raddr  = AW'(level_r - 1'b1);

  // walker row and column
  logic               div_start, div_done;
  logic [CELL_W-1:0]  row;
  logic [REG_W-1:0]   col;

  gmdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (walker_r),
    .divisor  (use_w),
    .done     (div_done),
    .quot     (row),
    .rem      (col)
  );

  // neighbor addresses and grid bounds, order top, right, bottom, left
  logic [CELL_W-1:0]  nb_addr [4];
  logic [3:0]         nb_in;

  always_comb begin
    nb_addr[0] = walker_r - CELL_W'(use_w);
    nb_addr[1] = walker_r + 1'b1;
    nb_addr[2] = walker_r + CELL_W'(use_w);
    nb_addr[3] = walker_r - 1'b1;
    nb_in[0]   = (row != '0);
    nb_in[1]   = ((8'(col) + 8'd1) < 8'(use_w));
    nb_in[2]   = ((13'(row) + 13'd1) < 13'(use_h));
    nb_in[3]   = (col != '0);
  end

  // neighbor choice: random mod count, then the k-th fresh neighbor
  logic [2:0]         n_fresh;
  logic [1:0]         k_sel;
  logic [1:0]         d_sel;
  logic [2:0]         seen;
  logic [15:0]        m3_prod;
  logic [7:0]         m3_q;
  logic [7:0]         m3_r;

  always_comb begin
    n_fresh = 3'($countones(fresh_r));
    m3_prod = 16'(rnd_r) * 16'd171;
    m3_q    = 8'(m3_prod >> 9);
    m3_r    = rnd_r - 8'(m3_q * 8'd3);
    case (n_fresh)
      3'd2:    k_sel = {1'b0, rnd_r[0]};
      3'd3:    k_sel = m3_r[1:0];
      3'd4:    k_sel = rnd_r[1:0];
      default: k_sel = 2'd0;
    endcase
    d_sel = 2'd0;
    seen  = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (fresh_r[i]) begin
        if (seen == {1'b0, k_sel}) begin
          d_sel = 2'(i);
        end
        seen = seen + 1'b1;
      end
    end
  end

  logic               in_grid;
  logic               walker_in;
  assign in_grid   = (TOT_W'(cell_r) < total_r);
  assign walker_in = (TOT_W'(walker_r) < total_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    kind_nxt       = kind_r;
    cell_nxt       = cell_r;
    blk_nxt        = blk_r;
    rnd_nxt        = rnd_r;
    grid_w_nxt     = grid_w_r;
    grid_h_nxt     = grid_h_r;
    walker_nxt     = walker_r;
    level_nxt      = level_r;
    count_nxt      = count_r;
    dir_cnt_nxt    = dir_cnt_r;
    fresh_nxt      = fresh_r;
    pick_nxt       = pick_r;
    nxt_cell_nxt   = nxt_cell_r;
    res_status_nxt = res_status_r;
    res_dir_nxt    = res_dir_r;
    res_walls_nxt  = res_walls_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_cell_nxt   = out_cell_r;
    out_dir_nxt    = out_dir_r;
    out_walls_nxt  = out_walls_r;
    out_left_nxt   = out_left_r;
    cm_we          = 1'b0;
    cm_waddr       = AW'(cell_r);
    cm_wdata       = cm_rdata;
    cm_raddr       = AW'(cell_r);
    sk_we          = 1'b0;
    div_start      = 1'b0;

    // configuration transfer
    if (cfg_valid) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_w_nxt = cfg_data;
      end
      if (cfg_index == REG_GRID_HEIGHT) begin
        grid_h_nxt = cfg_data;
      end
    end

    case (state_r)
      S_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_addr_r;
        cm_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt      = in_kind;
          cell_nxt      = in_cell_req;
          blk_nxt       = in_blocked;
          rnd_nxt       = in_random_value;
          res_dir_nxt   = 2'd0;
          res_walls_nxt = 4'd0;
          state_nxt     = S_DECODE;
        end
      end

      S_DECODE: begin
        case (kind_r)
          KIND_LOAD: begin
            res_status_nxt = ST_ACCEPTED;
            state_nxt      = in_grid ? S_LD_WR : S_DONE;
          end
          KIND_START: begin
            res_status_nxt = ST_STALLED;
            state_nxt      = in_grid ? S_ST_WR : S_DONE;
          end
          KIND_READ: begin
            res_status_nxt = ST_READ_DATA;
            state_nxt      = in_grid ? S_RD_CAP : S_DONE;
          end
          default: begin
            if (count_r == '0) begin
              res_status_nxt = ST_FINISHED;
              state_nxt      = S_DONE;
            end else if (walker_in) begin
              div_start = 1'b1;
              state_nxt = S_DIV_WAIT;
            end else begin
              fresh_nxt = 4'd0;
              state_nxt = S_CHOOSE;
            end
          end
        endcase
      end

      S_LD_WR: begin
        if (cm_rdata.loaded && !cm_rdata.blocked && !cm_rdata.visited
            && count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        if (!blk_r) begin
          count_nxt = count_nxt + 1'b1;
        end
        cm_we            = 1'b1;
        cm_wdata.loaded  = 1'b1;
        cm_wdata.blocked = blk_r;
        cm_wdata.visited = 1'b0;
        cm_wdata.walls   = 4'hF;
        state_nxt        = S_DONE;
      end

      S_ST_WR: begin
        if (!cm_rdata.blocked) begin
          if (!cm_rdata.visited && count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
          cm_we            = 1'b1;
          cm_wdata.visited = 1'b1;
          walker_nxt       = cell_r;
          level_nxt        = '0;
          res_status_nxt   = ST_ACCEPTED;
        end
        state_nxt = S_DONE;
      end

      S_RD_CAP: begin
        res_walls_nxt = cm_rdata.walls;
        state_nxt     = S_DONE;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          dir_cnt_nxt = 3'd0;
          fresh_nxt   = 4'd0;
          state_nxt   = S_NB;
        end
      end

      // read one neighbor per cycle, capture the previous one
      S_NB: begin
        if (dir_cnt_r != 3'd4) begin
          cm_raddr = AW'(nb_addr[dir_cnt_r[1:0]]);
        end
        if (dir_cnt_r != 3'd0) begin
          fresh_nxt[2'(dir_cnt_r - 1'b1)] = nb_in[2'(dir_cnt_r - 1'b1)]
              && !cm_rdata.blocked && !cm_rdata.visited;
        end
        dir_cnt_nxt = dir_cnt_r + 1'b1;
        if (dir_cnt_r == 3'd4) begin
          state_nxt = S_CHOOSE;
        end
      end

      S_CHOOSE: begin
        if (n_fresh != 3'd0) begin
          pick_nxt     = d_sel;
          nxt_cell_nxt = nb_addr[d_sel];
          cm_raddr     = AW'(walker_r);
          state_nxt    = S_CV_CUR;
        end else if (level_r != '0) begin
          state_nxt = S_POP;
        end else begin
          res_status_nxt = ST_STALLED;
          state_nxt      = S_DONE;
        end
      end

      // knock down the wall on the current cell, fetch the next cell
      S_CV_CUR: begin
        cm_we          = 1'b1;
        cm_waddr       = AW'(walker_r);
        cm_wdata.walls = cm_rdata.walls & ~(4'd1 << pick_r);
        cm_raddr       = AW'(nxt_cell_r);
        state_nxt      = S_CV_NXT;
      end

      S_CV_NXT: begin
        cm_we            = 1'b1;
        cm_waddr         = AW'(nxt_cell_r);
        cm_wdata.visited = 1'b1;
        cm_wdata.walls   = cm_rdata.walls & ~(4'd1 << (pick_r + 2'd2));
        count_nxt        = count_r - 1'b1;
        if (level_r < LVL_W'(CELLS)) begin
          sk_we     = 1'b1;
          level_nxt = level_r + 1'b1;
        end
        walker_nxt     = nxt_cell_r;
        res_status_nxt = ST_CARVED;
        res_dir_nxt    = pick_r;
        state_nxt      = S_DONE;
      end

      S_POP: begin
        level_nxt      = level_r - 1'b1;
        walker_nxt     = sk_rdata;
        res_status_nxt = ST_BACKTRACK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_cell_nxt   = walker_r;
          out_dir_nxt    = res_dir_r;
          out_walls_nxt  = res_walls_r;
          out_left_nxt   = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      grid_w_r    <= REG_W'(64);
      grid_h_r    <= REG_W'(64);
      walker_r    <= '0;
      level_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
      walker_r    <= walker_nxt;
      level_r     <= level_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    total_r      <= TOT_W'(use_w) * TOT_W'(use_h);
    kind_r       <= kind_nxt;
    cell_r       <= cell_nxt;
    blk_r        <= blk_nxt;
    rnd_r        <= rnd_nxt;
    dir_cnt_r    <= dir_cnt_nxt;
    fresh_r      <= fresh_nxt;
    pick_r       <= pick_nxt;
    nxt_cell_r   <= nxt_cell_nxt;
    res_status_r <= res_status_nxt;
    res_dir_r    <= res_dir_nxt;
    res_walls_r  <= res_walls_nxt;
    out_status_r <= out_status_nxt;
    out_cell_r   <= out_cell_nxt;
    out_dir_r    <= out_dir_nxt;
    out_walls_r  <= out_walls_nxt;
    out_left_r   <= out_left_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_current_cell     = out_cell_r;
  assign out_carved_direction = out_dir_r;
  assign out_wall_bits        = out_walls_r;
  assign out_cells_left       = 13'(out_left_r);

  // stack never grows past the grid capacity
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(CELLS))
    else $error("stack level past capacity");

  // a carve uses up exactly one unvisited cell
  a_carve_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CV_NXT |=> count_r == $past(count_r) - 1'b1)
    else $error("carve did not take one cell off the count");

  // a pop takes exactly one entry off the stack
  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> level_r == $past(level_r) - 1'b1)
    else $error("backtrack did not pop one entry");

  // the chosen direction is a fresh neighbor
  a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CV_CUR |-> fresh_r[pick_r])
    else $error("carve into a neighbor that is not fresh");

endmodule

/* sv/gmdc_ram.sv */
module gmdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gmdc_div.sv */
module gmdc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gmdc_pkg::CELL_W-1:0] dividend,
  input  logic [gmdc_pkg::REG_W-1:0]  divisor,
  output logic                       done,
  output logic [gmdc_pkg::CELL_W-1:0] quot,
  output logic [gmdc_pkg::REG_W-1:0]  rem
);
  import gmdc_pkg::*;

  localparam int CNT_W = $clog2(CELL_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CELL_W-1:0]  quot_r, quot_nxt;
  logic [REG_W-1:0]   rem_r, rem_nxt;
  logic [REG_W:0]     trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, quot_r[CELL_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt  = REG_W'(trial - {1'b0, divisor});
        quot_nxt = {quot_r[CELL_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[REG_W-1:0];
        quot_nxt = {quot_r[CELL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CELL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule
